/* src/lff_pkg.sv */
// ----------------------------------------------------------------------------
// lff_pkg
// Shared types, codes and constants of the indicator LED fade follower.
// ----------------------------------------------------------------------------
package lff_pkg;

  // number of steps of a linear fade
  localparam int unsigned FADE_STEP_COUNT = 20;

  // fade step index and its one-bit-wider compare form
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] FADE_N = CNT_W'(FADE_STEP_COUNT);

  // reciprocal for dividing an 8-bit level difference by the step count
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned FADE_RECIP  = (1 << RECIP_SHIFT) / FADE_STEP_COUNT;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DOWN_KEY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_UP_KEY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MOD_KEY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MOD_KEY  = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_MIN_LEVEL      = 8'd10;
  localparam logic [15:0] RST_OFF_DELAY_MS   = 16'd3000;
  localparam logic [15:0] RST_ADJUST_WINDOW  = 16'd250;
  localparam logic [9:0]  RST_FADE_STEP_MS   = 10'd20;
  localparam logic [7:0]  RST_SPEED_DOWN_KEY = 8'd35;
  localparam logic [7:0]  RST_SPEED_UP_KEY   = 8'd36;
  localparam logic [7:0]  RST_LEFT_MOD_KEY   = 8'd49;
  localparam logic [7:0]  RST_RIGHT_MOD_KEY  = 8'd50;

  // state reset values
  localparam logic [7:0] RST_PREV_BACKLIGHT = 8'd255;
  localparam logic [7:0] RST_VALID_LEVEL    = 8'd10;

  // word kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  typedef struct packed {
    logic [7:0]  min_level;
    logic [15:0] idle_delay;
    logic [15:0] adjust_window_ms;
    logic [9:0]  step_period;
    logic [7:0]  speed_down_key;
    logic [7:0]  speed_up_key;
    logic [7:0]  left_modifier_key;
    logic [7:0]  right_modifier_key;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_position;
    logic       key_pressed;
    logic [7:0] backlight_level;
  } item_t;

  typedef struct packed {
    logic [7:0] drive_lvl;
    logic [7:0] last_valid_level;
  } result_t;

endpackage

/* src/indicator_led_fade_follow.sv */
// ----------------------------------------------------------------------------
// indicator_led_fade_follow
// Indicator LED level controller that follows deliberate backlight changes.
// Each input word is a 1 ms tick, a key press or release, or a backlight
// sample, and each produces exactly one result word carrying the LED level
// and the last deliberately set level. The first sample after reset sets the
// boot level; later samples move the LED only after a speed key was pressed
// with a modifier held inside the adjust window. A dark LED fades in over
// FADE_STEP_COUNT steps, a lit one jumps, and an idle timeout fades it to
// zero. Rate is one word per clock while the result side does not stall; an
// accepted word sits in the input register, a single pass of update logic
// runs, and the result register loads it. A stalled result holds the input
// register, which then stalls the input in the same cycle. Configuration
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module indicator_led_fade_follow (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [lff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lff_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [7:0]                     key_position_i,
  input  logic                           key_pressed_i,
  input  logic [7:0]                     backlight_level_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     led_level_o,
  output logic [7:0]                     last_valid_level_o
);

  lff_pkg::cfg_t    cfg;
  lff_pkg::item_t   item_q;
  lff_pkg::result_t result;
  lff_pkg::result_t out_q;

  logic in_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic advance;

  // result register can take a word when empty or when its word leaves now
  assign out_ready  = !out_valid_q || !out_stall_i;
  // held word moves into the state and result register
  assign advance    = in_valid_q && out_ready;
  // input register frees up whenever its word advances
  assign in_stall_o = in_valid_q && !out_ready;

  lff_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register: word payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.kind            <= kind_i;
      item_q.key_position    <= key_position_i;
      item_q.key_pressed     <= key_pressed_i;
      item_q.backlight_level <= backlight_level_i;
    end
  end

  // LED state and its update, committed when the word advances
  lff_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .fire_i   (advance),
    .result_o (result)
  );

  // result register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  // result register: word payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign led_level_o        = out_q.drive_lvl;
  assign last_valid_level_o = out_q.last_valid_level;

endmodule

/* src/lff_cfg.sv */
// ----------------------------------------------------------------------------
// lff_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module lff_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lff_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lff_pkg::cfg_t                  cfg_o
);

  lff_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lff_pkg::REG_MIN_LEVEL:      cfg_d.min_level          = cfg_wdata_i[7:0];
        lff_pkg::REG_OFF_DELAY_MS:   cfg_d.idle_delay         = cfg_wdata_i[15:0];
        lff_pkg::REG_ADJUST_WINDOW:  cfg_d.adjust_window_ms   = cfg_wdata_i[15:0];
        lff_pkg::REG_FADE_STEP_MS:   cfg_d.step_period        = cfg_wdata_i[9:0];
        lff_pkg::REG_SPEED_DOWN_KEY: cfg_d.speed_down_key     = cfg_wdata_i[7:0];
        lff_pkg::REG_SPEED_UP_KEY:   cfg_d.speed_up_key       = cfg_wdata_i[7:0];
        lff_pkg::REG_LEFT_MOD_KEY:   cfg_d.left_modifier_key  = cfg_wdata_i[7:0];
        lff_pkg::REG_RIGHT_MOD_KEY:  cfg_d.right_modifier_key = cfg_wdata_i[7:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level          <= lff_pkg::RST_MIN_LEVEL;
      cfg_q.idle_delay         <= lff_pkg::RST_OFF_DELAY_MS;
      cfg_q.adjust_window_ms   <= lff_pkg::RST_ADJUST_WINDOW;
      cfg_q.step_period        <= lff_pkg::RST_FADE_STEP_MS;
      cfg_q.speed_down_key     <= lff_pkg::RST_SPEED_DOWN_KEY;
      cfg_q.speed_up_key       <= lff_pkg::RST_SPEED_UP_KEY;
      cfg_q.left_modifier_key  <= lff_pkg::RST_LEFT_MOD_KEY;
      cfg_q.right_modifier_key <= lff_pkg::RST_RIGHT_MOD_KEY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/lff_core.sv */
// ----------------------------------------------------------------------------
// lff_core
// LED state and its single-pass update for one tick, key or sample word.
// ----------------------------------------------------------------------------
module lff_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lff_pkg::cfg_t    cfg_i,
  input  lff_pkg::item_t   item_i,
  input  logic             fire_i,
  output lff_pkg::result_t result_o
);

  localparam int unsigned IW = lff_pkg::IDX_W;
  localparam int unsigned CW = lff_pkg::CNT_W;
  localparam int unsigned PW = 8 + lff_pkg::RECIP_W;

  typedef struct packed {
    logic          up;
    logic [7:0]    quo;
    logic [IW-1:0] rem;
  } setup_t;

  // difference over step count, split into per-step quotient and remainder
  function automatic setup_t fade_setup(logic [7:0] origin, logic [7:0] target);
    logic [7:0]    diff;
    logic [PW-1:0] prod;
    logic [7:0]    q;
    logic [13:0]   qn;
    logic [13:0]   rem;
    setup_t        s;
    s.up = (target >= origin);
    diff = s.up ? (target - origin) : (origin - target);
    prod = {{lff_pkg::RECIP_W{1'b0}}, diff}
         * {8'b0, lff_pkg::RECIP_W'(lff_pkg::FADE_RECIP)};
    q    = prod[lff_pkg::RECIP_SHIFT +: 8];
    qn   = {6'b0, q} * 14'(lff_pkg::FADE_STEP_COUNT);
    rem  = {6'b0, diff} - qn;
    // estimate is at most one low
    if (rem >= 14'(lff_pkg::FADE_STEP_COUNT)) begin
      q   = q + 8'd1;
      rem = rem - 14'(lff_pkg::FADE_STEP_COUNT);
    end
    s.quo = q;
    s.rem = rem[IW-1:0];
    return s;
  endfunction

  logic          booted_q, booted_d;
  logic [7:0]    prev_bl_q, prev_bl_d;
  logic [7:0]    drive_q, drive_d;
  logic [7:0]    target_q, target_d;
  logic [7:0]    origin_q, origin_d;
  logic          up_q, up_d;
  logic [7:0]    step_quo_q, step_quo_d;
  logic [IW-1:0] step_rem_q, step_rem_d;
  logic [7:0]    acc_quo_q, acc_quo_d;
  logic [IW-1:0] acc_rem_q, acc_rem_d;
  logic          running_q, running_d;
  logic [IW-1:0] index_q, index_d;
  logic [9:0]    fade_cnt_q, fade_cnt_d;
  logic [15:0]   off_cnt_q, off_cnt_d;
  logic          off_armed_q, off_armed_d;
  logic          adj_pending_q, adj_pending_d;
  logic [15:0]   adj_age_q, adj_age_d;
  logic          left_held_q, left_held_d;
  logic          right_held_q, right_held_d;
  logic [7:0]    valid_q, valid_d;

  always_comb begin
    logic          sf_start;
    logic [7:0]    sf_target;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] rem_sum;
    logic [CW-1:0] rem_wrap;
    logic [7:0]    lvl_min;
    logic          speed_key;
    setup_t        setup;

    booted_d      = booted_q;
    prev_bl_d     = prev_bl_q;
    drive_d       = drive_q;
    target_d      = target_q;
    origin_d      = origin_q;
    up_d          = up_q;
    step_quo_d    = step_quo_q;
    step_rem_d    = step_rem_q;
    acc_quo_d     = acc_quo_q;
    acc_rem_d     = acc_rem_q;
    running_d     = running_q;
    index_d       = index_q;
    fade_cnt_d    = fade_cnt_q;
    off_cnt_d     = off_cnt_q;
    off_armed_d   = off_armed_q;
    adj_pending_d = adj_pending_q;
    adj_age_d     = adj_age_q;
    left_held_d   = left_held_q;
    right_held_d  = right_held_q;
    valid_d       = valid_q;

    sf_start  = 1'b0;
    sf_target = 8'd0;
    idx_next  = {1'b0, index_q} + CW'(1);
    rem_sum   = {1'b0, acc_rem_q} + {1'b0, step_rem_q};
    rem_wrap  = rem_sum - lff_pkg::FADE_N;
    lvl_min   = (item_i.backlight_level < cfg_i.min_level) ?
                cfg_i.min_level : item_i.backlight_level;
    speed_key = (item_i.key_position == cfg_i.speed_down_key) ||
                (item_i.key_position == cfg_i.speed_up_key);

    case (item_i.kind)
      lff_pkg::KIND_TICK: begin
        if (adj_age_q != 16'hFFFF) begin
          adj_age_d = adj_age_q + 16'd1;
        end
        if (booted_q) begin
          if (running_q) begin
            if (fade_cnt_q < 10'd2) begin
              drive_d = up_q ? (origin_q + acc_quo_q) : (origin_q - acc_quo_q);
              if (idx_next > lff_pkg::FADE_N) begin
                drive_d   = target_q;
                running_d = 1'b0;
                index_d   = '0;
              end else begin
                index_d    = idx_next[IW-1:0];
                fade_cnt_d = cfg_i.step_period;
                if (rem_sum >= lff_pkg::FADE_N) begin
                  acc_quo_d = acc_quo_q + step_quo_q + 8'd1;
                  acc_rem_d = rem_wrap[IW-1:0];
                end else begin
                  acc_quo_d = acc_quo_q + step_quo_q;
                  acc_rem_d = rem_sum[IW-1:0];
                end
              end
            end else begin
              fade_cnt_d = fade_cnt_q - 10'd1;
            end
          end
          if (off_armed_q) begin
            if (off_cnt_q < 16'd2) begin
              off_armed_d = 1'b0;
              off_cnt_d   = '0;
              sf_start    = 1'b1;
              sf_target   = 8'd0;
            end else begin
              off_cnt_d = off_cnt_q - 16'd1;
            end
          end
        end
      end
      lff_pkg::KIND_KEY: begin
        if (item_i.key_position == cfg_i.left_modifier_key) begin
          left_held_d = item_i.key_pressed;
        end else if (item_i.key_position == cfg_i.right_modifier_key) begin
          right_held_d = item_i.key_pressed;
        end
        if (item_i.key_pressed && (left_held_d || right_held_d) && speed_key) begin
          adj_age_d     = '0;
          adj_pending_d = 1'b1;
        end
      end
      lff_pkg::KIND_SAMPLE: begin
        if (!booted_q) begin
          // boot level: zero stays dark, anything else at least the floor
          booted_d  = 1'b1;
          prev_bl_d = item_i.backlight_level;
          drive_d   = (item_i.backlight_level == 8'd0) ? 8'd0 : lvl_min;
          if (item_i.backlight_level != 8'd0) begin
            valid_d = lvl_min;
          end
          off_armed_d = 1'b1;
          off_cnt_d   = cfg_i.idle_delay;
        end else if (item_i.backlight_level != prev_bl_q) begin
          prev_bl_d     = item_i.backlight_level;
          adj_pending_d = 1'b0;
          if (adj_pending_q && (adj_age_q <= cfg_i.adjust_window_ms)) begin
            valid_d = lvl_min;
            if (drive_q == 8'd0) begin
              sf_start  = 1'b1;
              sf_target = lvl_min;
            end else begin
              running_d  = 1'b0;
              index_d    = '0;
              fade_cnt_d = '0;
              drive_d    = lvl_min;
            end
            off_armed_d = 1'b1;
            off_cnt_d   = cfg_i.idle_delay;
          end
        end
      end
      default: begin
      end
    endcase

    // new fade starts from the level reached so far in this word
    setup = fade_setup(drive_d, sf_target);
    if (sf_start) begin
      origin_d   = drive_d;
      target_d   = sf_target;
      up_d       = setup.up;
      step_quo_d = setup.quo;
      step_rem_d = setup.rem;
      acc_quo_d  = '0;
      acc_rem_d  = '0;
      index_d    = '0;
      running_d  = 1'b1;
      fade_cnt_d = cfg_i.step_period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      booted_q      <= 1'b0;
      prev_bl_q     <= lff_pkg::RST_PREV_BACKLIGHT;
      drive_q       <= '0;
      target_q      <= '0;
      origin_q      <= '0;
      up_q          <= 1'b1;
      step_quo_q    <= '0;
      step_rem_q    <= '0;
      acc_quo_q     <= '0;
      acc_rem_q     <= '0;
      running_q     <= 1'b0;
      index_q       <= '0;
      fade_cnt_q    <= '0;
      off_cnt_q     <= '0;
      off_armed_q   <= 1'b0;
      adj_pending_q <= 1'b0;
      adj_age_q     <= '0;
      left_held_q   <= 1'b0;
      right_held_q  <= 1'b0;
      valid_q       <= lff_pkg::RST_VALID_LEVEL;
    end else if (fire_i) begin
      booted_q      <= booted_d;
      prev_bl_q     <= prev_bl_d;
      drive_q       <= drive_d;
      target_q      <= target_d;
      origin_q      <= origin_d;
      up_q          <= up_d;
      step_quo_q    <= step_quo_d;
      step_rem_q    <= step_rem_d;
      acc_quo_q     <= acc_quo_d;
      acc_rem_q     <= acc_rem_d;
      running_q     <= running_d;
      index_q       <= index_d;
      fade_cnt_q    <= fade_cnt_d;
      off_cnt_q     <= off_cnt_d;
      off_armed_q   <= off_armed_d;
      adj_pending_q <= adj_pending_d;
      adj_age_q     <= adj_age_d;
      left_held_q   <= left_held_d;
      right_held_q  <= right_held_d;
      valid_q       <= valid_d;
    end
  end

  assign result_o.drive_lvl        = drive_d;
  assign result_o.last_valid_level = valid_d;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indicator LED fade follower. Words go in
// through the valid/stall channel and come back one result word each. A
// behavioral copy of the LED logic predicts every result that the table does
// not type in. A short table covers boot, modifier and speed keys, ignored
// kinds and level extremes. Random phases then run key/sample/tick sequences
// under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // the spare kind code carries no function and must be ignored
  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // one line of the directed table: word, whether a level is typed in, levels
  typedef struct packed {
    lff_pkg::item_t   w;
    logic             chk;
    lff_pkg::result_t exp;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = '0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  kind       = lff_pkg::KIND_TICK;
  logic [7:0]  key_pos    = '0;
  logic        key_pr     = 1'b0;
  logic [7:0]  backlight  = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  led_out;
  logic [7:0]  last_valid;

  // typed expectation riding along with the word on the input channel
  logic             row_chk = 1'b0;
  lff_pkg::result_t row_exp = '0;

  // no idling on either side while set
  logic        calm       = 1'b0;

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // levels still owed by the block, oldest first
  lff_pkg::result_t pending_levels [$];

  // behavioral copy of registers and state
  lff_pkg::cfg_t m_cfg;
  logic        m_booted, m_run, m_off_armed, m_pending, m_left, m_right;
  logic [7:0]  m_prev, m_drive, m_target, m_origin, m_valid;
  logic [4:0]  m_index;
  logic [9:0]  m_fade_cnt;
  logic [15:0] m_off_cnt, m_age;

  indicator_led_fade_follow DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (kind),
    .key_position_i     (key_pos),
    .key_pressed_i      (key_pr),
    .backlight_level_i  (backlight),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .led_level_o        (led_out),
    .last_valid_level_o (last_valid)
  );

  // directed table, reset register values assumed throughout
  row_t dir_rows [21] = '{
    // tick before boot, stray key and level fields must not matter
    '{'{lff_pkg::KIND_TICK,   8'd49,  1'b1, 8'd200}, 1'b1, '{8'd0,   8'd10}},
    '{'{KIND_SPARE,           8'd255, 1'b1, 8'd255}, 1'b1, '{8'd0,   8'd10}},
    // modifier then speed key before boot, adjust still gets armed
    '{'{lff_pkg::KIND_KEY,    8'd49,  1'b1, 8'd0},   1'b1, '{8'd0,   8'd10}},
    '{'{lff_pkg::KIND_KEY,    8'd36,  1'b1, 8'd0},   1'b1, '{8'd0,   8'd10}},
    '{'{lff_pkg::KIND_TICK,   8'd0,   1'b0, 8'd0},   1'b0, '{8'd0,   8'd0}},
    // boot level below the floor is raised
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd3},   1'b1, '{8'd10,  8'd10}},
    // armed adjust, lit LED jumps to full scale
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd255}, 1'b1, '{8'd255, 8'd255}},
    // repeated level is no change
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd255}, 1'b1, '{8'd255, 8'd255}},
    // adjust already used up
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd0},   1'b1, '{8'd255, 8'd255}},
    '{'{lff_pkg::KIND_KEY,    8'd49,  1'b0, 8'd0},   1'b1, '{8'd255, 8'd255}},
    // speed key with no modifier held
    '{'{lff_pkg::KIND_KEY,    8'd35,  1'b1, 8'd0},   1'b1, '{8'd255, 8'd255}},
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd100}, 1'b1, '{8'd255, 8'd255}},
    // right modifier with speed down, zero level lands on the floor
    '{'{lff_pkg::KIND_KEY,    8'd50,  1'b1, 8'd0},   1'b1, '{8'd255, 8'd255}},
    '{'{lff_pkg::KIND_KEY,    8'd35,  1'b1, 8'd0},   1'b1, '{8'd255, 8'd255}},
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd0},   1'b1, '{8'd10,  8'd10}},
    '{'{lff_pkg::KIND_KEY,    8'd255, 1'b1, 8'd255}, 1'b0, '{8'd0,   8'd0}},
    '{'{lff_pkg::KIND_KEY,    8'd36,  1'b1, 8'd0},   1'b0, '{8'd0,   8'd0}},
    '{'{lff_pkg::KIND_TICK,   8'd255, 1'b0, 8'd255}, 1'b0, '{8'd0,   8'd0}},
    '{'{lff_pkg::KIND_SAMPLE, 8'd0,   1'b0, 8'd7},   1'b1, '{8'd10,  8'd10}},
    '{'{lff_pkg::KIND_KEY,    8'd50,  1'b0, 8'd0},   1'b0, '{8'd0,   8'd0}},
    '{'{lff_pkg::KIND_KEY,    8'd0,   1'b0, 8'd0},   1'b0, '{8'd0,   8'd0}}
  };

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls at random except in calm stretches
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // behavioral LED logic
  // ---------------------------------------------------------------------------

  // new linear fade from the present level
  function automatic void begin_fade(input logic [7:0] target);
    m_origin   = m_drive;
    m_target   = target;
    m_index    = '0;
    m_run      = 1'b1;
    m_fade_cnt = m_cfg.step_period;
  endfunction

  // one fade step, quotient truncated toward zero
  function automatic void fade_advance();
    int unsigned t, o, q, nxt;
    t = m_target;
    o = m_origin;
    if (t >= o) begin
      q = ((t - o) * m_index) / lff_pkg::FADE_STEP_COUNT;
      m_drive = 8'(o + q);
    end else begin
      q = ((o - t) * m_index) / lff_pkg::FADE_STEP_COUNT;
      m_drive = 8'(o - q);
    end
    nxt = m_index + 1;
    if (nxt > lff_pkg::FADE_STEP_COUNT) begin
      // last step lands exactly on the target
      m_drive = m_target;
      m_run   = 1'b0;
      m_index = '0;
    end else begin
      m_index    = 5'(nxt);
      m_fade_cnt = m_cfg.step_period;
    end
  endfunction

  function automatic void model_tick();
    // adjust age saturates
    if (m_age != 16'hFFFF) m_age = m_age + 16'd1;
    if (!m_booted) return;
    // a zero count expires like a count of one
    if (m_run) begin
      if (m_fade_cnt <= 10'd1) fade_advance();
      else m_fade_cnt = m_fade_cnt - 10'd1;
    end
    // off timeout after the fade step, restarting any fade toward dark
    if (m_off_armed) begin
      if (m_off_cnt <= 16'd1) begin
        m_off_armed = 1'b0;
        m_off_cnt   = '0;
        begin_fade(8'd0);
      end else begin
        m_off_cnt = m_off_cnt - 16'd1;
      end
    end
  endfunction

  function automatic void model_key(input logic [7:0] pos, input logic pr);
    if (pos == m_cfg.left_modifier_key) m_left = pr;
    else if (pos == m_cfg.right_modifier_key) m_right = pr;
    if (pr && (m_left || m_right) &&
        (pos == m_cfg.speed_down_key || pos == m_cfg.speed_up_key)) begin
      m_age     = '0;
      m_pending = 1'b1;
    end
  endfunction

  function automatic void model_sample(input logic [7:0] b);
    logic [7:0] lvl;
    logic       adjusted;
    if (!m_booted) begin
      // boot level: dark stays dark, anything else at least the floor
      m_booted = 1'b1;
      lvl = (b == 8'd0) ? 8'd0 : ((b < m_cfg.min_level) ? m_cfg.min_level : b);
      m_prev = b;
      if (lvl != 8'd0) m_valid = lvl;
      m_drive     = lvl;
      m_off_armed = 1'b1;
      m_off_cnt   = m_cfg.idle_delay;
      return;
    end
    if (b == m_prev) return;
    m_prev    = b;
    adjusted  = m_pending && (m_age <= m_cfg.adjust_window_ms);
    m_pending = 1'b0;
    if (!adjusted) return;
    // a zero floor lets a zero level through
    lvl     = (b < m_cfg.min_level) ? m_cfg.min_level : b;
    m_valid = lvl;
    if (m_drive == 8'd0) begin
      begin_fade(lvl);
    end else begin
      m_run      = 1'b0;
      m_index    = '0;
      m_fade_cnt = '0;
      m_drive    = lvl;
    end
    m_off_armed = 1'b1;
    m_off_cnt   = m_cfg.idle_delay;
  endfunction

  // apply one word, return the levels it leaves on the outputs
  function automatic lff_pkg::result_t follow_word(input lff_pkg::item_t w);
    lff_pkg::result_t r;
    case (w.kind)
      lff_pkg::KIND_TICK:   model_tick();
      lff_pkg::KIND_KEY:    model_key(w.key_position, w.key_pressed);
      lff_pkg::KIND_SAMPLE: model_sample(w.backlight_level);
      default: ;
    endcase
    r.drive_lvl        = m_drive;
    r.last_valid_level = m_valid;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, accepted words, returned levels
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    lff_pkg::item_t   w;
    lff_pkg::result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          lff_pkg::REG_MIN_LEVEL:      m_cfg.min_level          = cfg_wdata[7:0];
          lff_pkg::REG_OFF_DELAY_MS:   m_cfg.idle_delay         = cfg_wdata;
          lff_pkg::REG_ADJUST_WINDOW:  m_cfg.adjust_window_ms   = cfg_wdata;
          lff_pkg::REG_FADE_STEP_MS:   m_cfg.step_period        = cfg_wdata[9:0];
          lff_pkg::REG_SPEED_DOWN_KEY: m_cfg.speed_down_key     = cfg_wdata[7:0];
          lff_pkg::REG_SPEED_UP_KEY:   m_cfg.speed_up_key       = cfg_wdata[7:0];
          lff_pkg::REG_LEFT_MOD_KEY:   m_cfg.left_modifier_key  = cfg_wdata[7:0];
          lff_pkg::REG_RIGHT_MOD_KEY:  m_cfg.right_modifier_key = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        w.kind            = kind;
        w.key_position    = key_pos;
        w.key_pressed     = key_pr;
        w.backlight_level = backlight;
        want = follow_word(w);
        // typed table levels take the place of the prediction
        if (row_chk) want = row_exp;
        pending_levels.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          report_mismatch($sformatf("result word %0d/%0d with nothing pending",
                                    led_out, last_valid));
        end else begin
          want = pending_levels.pop_front();
          if (led_out !== want.drive_lvl)
            report_mismatch($sformatf("led level %0d, want %0d",
                                      led_out, want.drive_lvl));
          if (last_valid !== want.last_valid_level)
            report_mismatch($sformatf("last_valid_level %0d, want %0d",
                                      last_valid, want.last_valid_level));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // word builders, unused fields get random content
  function automatic lff_pkg::item_t tick_word();
    lff_pkg::item_t w;
    w.kind            = lff_pkg::KIND_TICK;
    w.key_position    = 8'($urandom_range(0, 255));
    w.key_pressed     = 1'($urandom_range(0, 1));
    w.backlight_level = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic lff_pkg::item_t key_word(input logic [7:0] pos, input logic pr);
    lff_pkg::item_t w;
    w = tick_word();
    w.kind         = lff_pkg::KIND_KEY;
    w.key_position = pos;
    w.key_pressed  = pr;
    return w;
  endfunction

  function automatic lff_pkg::item_t sample_word(input logic [7:0] b);
    lff_pkg::item_t w;
    w = tick_word();
    w.kind            = lff_pkg::KIND_SAMPLE;
    w.backlight_level = b;
    return w;
  endfunction

  // offer one word and hold it until taken; valid stays high on return
  task automatic send_word(input lff_pkg::item_t w, input logic chk,
                           input lff_pkg::result_t want);
    while (!calm && ($urandom_range(0, 99) < 12)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= w.kind;
    key_pos   <= w.key_position;
    key_pr    <= w.key_pressed;
    backlight <= w.backlight_level;
    row_chk   <= chk;
    row_exp   <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // registers change only once every level owed has come back
  task automatic load_settings(input lff_pkg::cfg_t c);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(lff_pkg::REG_MIN_LEVEL,      16'(c.min_level));
    write_reg(lff_pkg::REG_OFF_DELAY_MS,   c.idle_delay);
    write_reg(lff_pkg::REG_ADJUST_WINDOW,  c.adjust_window_ms);
    write_reg(lff_pkg::REG_FADE_STEP_MS,   16'(c.step_period));
    write_reg(lff_pkg::REG_SPEED_DOWN_KEY, 16'(c.speed_down_key));
    write_reg(lff_pkg::REG_SPEED_UP_KEY,   16'(c.speed_up_key));
    write_reg(lff_pkg::REG_LEFT_MOD_KEY,   16'(c.left_modifier_key));
    write_reg(lff_pkg::REG_RIGHT_MOD_KEY,  16'(c.right_modifier_key));
    cfg_we <= 1'b0;
  endtask

  // mostly modifier + speed key + sample sequences, the rest loose words
  task automatic random_traffic(input int unsigned n_words);
    int unsigned    stop, spread, longest, pick;
    logic [7:0]     mod_key, spd_key, lvl;
    lff_pkg::item_t w;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        mod_key = $urandom_range(0, 1) ? m_cfg.left_modifier_key
                                       : m_cfg.right_modifier_key;
        spd_key = $urandom_range(0, 1) ? m_cfg.speed_down_key
                                       : m_cfg.speed_up_key;
        send_word(key_word(mod_key, 1'b1), 1'b0, '0);
        repeat ($urandom_range(0, 2)) send_word(tick_word(), 1'b0, '0);
        send_word(key_word(spd_key, 1'b1), 1'b0, '0);
        // gap straddles the adjust window when it is at most 40, else stays inside it
        spread = (m_cfg.adjust_window_ms > 40) ? 40 : m_cfg.adjust_window_ms + 2;
        repeat ($urandom_range(0, spread)) send_word(tick_word(), 1'b0, '0);
        pick = $urandom_range(0, 9);
        if (pick == 0) lvl = m_prev;
        else if (pick == 1) lvl = 8'd0;
        else if (pick == 2) lvl = 8'd255;
        else lvl = 8'($urandom_range(0, 255));
        send_word(sample_word(lvl), 1'b0, '0);
        // now and then long enough for the off timeout and a whole fade, capped at 200 ticks
        longest = m_cfg.idle_delay + 21 * m_cfg.step_period + 4;
        if (longest > 200) longest = 200;
        spread = ($urandom_range(0, 3) == 0) ? longest : 8;
        repeat ($urandom_range(0, spread)) send_word(tick_word(), 1'b0, '0);
        if ($urandom_range(0, 1)) send_word(key_word(mod_key, 1'b0), 1'b0, '0);
        if ($urandom_range(0, 1)) send_word(key_word(spd_key, 1'b0), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          w = tick_word();
          w.kind = 2'($urandom_range(0, 3));
          send_word(w, 1'b0, '0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    lff_pkg::cfg_t c;
    // register and state values after reset
    m_cfg.min_level          = lff_pkg::RST_MIN_LEVEL;
    m_cfg.idle_delay         = lff_pkg::RST_OFF_DELAY_MS;
    m_cfg.adjust_window_ms   = lff_pkg::RST_ADJUST_WINDOW;
    m_cfg.step_period        = lff_pkg::RST_FADE_STEP_MS;
    m_cfg.speed_down_key     = lff_pkg::RST_SPEED_DOWN_KEY;
    m_cfg.speed_up_key       = lff_pkg::RST_SPEED_UP_KEY;
    m_cfg.left_modifier_key  = lff_pkg::RST_LEFT_MOD_KEY;
    m_cfg.right_modifier_key = lff_pkg::RST_RIGHT_MOD_KEY;
    m_booted = 1'b0;  m_run = 1'b0;  m_off_armed = 1'b0;  m_pending = 1'b0;
    m_left = 1'b0;    m_right = 1'b0;
    m_prev = lff_pkg::RST_PREV_BACKLIGHT;
    m_drive = '0;  m_target = '0;  m_origin = '0;
    m_valid = lff_pkg::RST_VALID_LEVEL;  m_index = '0;  m_fade_cnt = '0;
    m_off_cnt = '0;   m_age = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under reset settings
    foreach (dir_rows[r]) send_word(dir_rows[r].w, dir_rows[r].chk, dir_rows[r].exp);
    random_traffic(35);

    // low extremes, zero delays act as one
    c.min_level          = 8'd0;
    c.idle_delay         = 16'd0;
    c.adjust_window_ms   = 16'd0;
    c.step_period        = 10'd0;
    c.speed_down_key     = 8'd0;
    c.speed_up_key       = 8'd1;
    c.left_modifier_key  = 8'd2;
    c.right_modifier_key = 8'd3;
    load_settings(c);
    random_traffic(60);

    // high extremes
    c.min_level          = 8'd255;
    c.idle_delay         = 16'hFFFF;
    c.adjust_window_ms   = 16'hFFFF;
    c.step_period        = 10'h3FF;
    c.speed_down_key     = 8'd255;
    c.speed_up_key       = 8'd254;
    c.left_modifier_key  = 8'd253;
    c.right_modifier_key = 8'd252;
    load_settings(c);
    random_traffic(35);

    // random settings with short timers so fades complete; middle one calm
    for (int p = 0; p < 3; p++) begin
      c.min_level          = 8'($urandom_range(0, 255));
      c.idle_delay         = 16'($urandom_range(1, 90));
      c.adjust_window_ms   = 16'($urandom_range(0, 50));
      c.step_period        = 10'($urandom_range(1, 3));
      c.speed_down_key     = 8'($urandom_range(0, 255));
      c.speed_up_key       = 8'($urandom_range(0, 255));
      c.left_modifier_key  = 8'($urandom_range(0, 255));
      c.right_modifier_key = 8'($urandom_range(0, 255));
      calm <= (p == 1);
      load_settings(c);
      random_traffic(80);
    end
    calm <= 1'b0;

    // drain and settle
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
